// ===== rtl/ssp_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types.
package ssp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

    localparam logic [ROWS_CFG_W-1:0] FRAME_ROWS_RESET = 7'd4;
    localparam logic [COLS_CFG_W-1:0] FRAME_COLS_RESET = 6'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rd_en;     // read column word, capture sample on a normal read
        logic col_step;  // shift window, write back column word
        logic flush;     // last-row sweep: no write back, end flag on last word
        logic row_ge1;   // row above exists
        logic row_ge2;   // row two above exists
        logic left1;     // column to the left exists
        logic left2;     // column two to the left exists
        logic load_a;    // load result for column minus one
        logic load_b;    // load result for the last column
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
    } dp_status_t;

endpackage

// ===== rtl/ssp_ctrl.sv =====
// Controller: frame size registers, raster position and step sequencing.
module ssp_ctrl
    import ssp_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_status_t            status,
    output dp_cmd_t               cmd,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_addr
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_EMIT_A,
        S_EMIT_B,
        S_FLUSH_RD
    } state_t;

    state_t                  state_reg,    state_next;
    logic [ROW_W-1:0]        row_pos_reg,  row_pos_next;
    logic [COL_W-1:0]        col_pos_reg,  col_pos_next;
    logic [COL_W-1:0]        step_col_reg, step_col_next;
    logic                    ge1_reg,      ge1_next;
    logic                    ge2_reg,      ge2_next;
    logic                    flush_reg,    flush_next;
    logic                    last_reg,     last_next;
    logic [ROWS_CFG_W-1:0]   rows_cfg_reg, rows_cfg_next;
    logic [COLS_CFG_W-1:0]   cols_cfg_reg, cols_cfg_next;

    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] r_eff;
    logic [COL_W-1:0] c_eff;
    logic             emit_ok;
    logic             at_last_col;
    state_t           after_state;
    logic [COL_W-1:0] after_col;
    logic             after_flush;
    logic             after_ge1;

    // Clamp the size registers into 1..MAX.
    always_comb
    begin
        if (rows_cfg_reg == '0)
            last_row = '0;
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            last_row = ROW_W'(MAX_ROWS - 1);
        else
            last_row = ROW_W'(rows_cfg_reg - ROWS_CFG_W'(1));

        if (cols_cfg_reg == '0)
            last_col = '0;
        else if (32'(cols_cfg_reg) > MAX_COLS)
            last_col = COL_W'(MAX_COLS - 1);
        else
            last_col = COL_W'(cols_cfg_reg - COLS_CFG_W'(1));
    end

    always_comb
    begin
        if ((row_pos_reg > last_row) || (col_pos_reg > last_col))
        begin
            r_eff = '0;
            c_eff = '0;
        end
        else
        begin
            r_eff = row_pos_reg;
            c_eff = col_pos_reg;
        end
    end

    assign emit_ok     = flush_reg | ge1_reg;
    assign at_last_col = (step_col_reg == last_col);

    // Where to go once all results of one column step are out.
    always_comb
    begin
        after_state = S_IDLE;
        after_col   = step_col_reg;
        after_flush = flush_reg;
        after_ge1   = ge1_reg;
        if (flush_reg)
        begin
            if (!at_last_col)
            begin
                after_state = S_FLUSH_RD;
                after_col   = step_col_reg + COL_W'(1);
            end
        end
        else if (last_reg)
        begin
            after_state = S_FLUSH_RD;
            after_col   = '0;
            after_flush = 1'b1;
            after_ge1   = (last_row != '0);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        step_col_next = step_col_reg;
        ge1_next      = ge1_reg;
        ge2_next      = ge2_reg;
        flush_next    = flush_reg;
        last_next     = last_reg;
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    unique case (cfg_index)
                        REG_FRAME_ROWS:
                        begin
                            rows_cfg_next = cfg_data[ROWS_CFG_W-1:0];
                            row_pos_next  = '0;
                            col_pos_next  = '0;
                        end
                        REG_FRAME_COLS:
                        begin
                            cols_cfg_next = cfg_data[COLS_CFG_W-1:0];
                            row_pos_next  = '0;
                            col_pos_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_valid)
                begin
                    step_col_next = c_eff;
                    ge1_next      = (r_eff != '0);
                    ge2_next      = (r_eff > ROW_W'(1));
                    flush_next    = 1'b0;
                    last_next     = (r_eff == last_row) && (c_eff == last_col);
                    if ((r_eff == last_row) && (c_eff == last_col))
                    begin
                        row_pos_next = '0;
                        col_pos_next = '0;
                    end
                    else if (c_eff == last_col)
                    begin
                        row_pos_next = r_eff + ROW_W'(1);
                        col_pos_next = '0;
                    end
                    else
                    begin
                        row_pos_next = r_eff;
                        col_pos_next = c_eff + COL_W'(1);
                    end
                    state_next = S_COL;
                end
            end
            S_COL:
            begin
                if (emit_ok && (step_col_reg != '0))
                    state_next = S_EMIT_A;
                else if (emit_ok && at_last_col)
                    state_next = S_EMIT_B;
                else
                begin
                    state_next    = after_state;
                    step_col_next = after_col;
                    flush_next    = after_flush;
                    ge1_next      = after_ge1;
                end
            end
            S_EMIT_A:
            begin
                if (status.out_free)
                begin
                    if (at_last_col)
                        state_next = S_EMIT_B;
                    else
                    begin
                        state_next    = after_state;
                        step_col_next = after_col;
                        flush_next    = after_flush;
                        ge1_next      = after_ge1;
                    end
                end
            end
            S_EMIT_B:
            begin
                if (status.out_free)
                begin
                    state_next    = after_state;
                    step_col_next = after_col;
                    flush_next    = after_flush;
                    ge1_next      = after_ge1;
                end
            end
            S_FLUSH_RD:
            begin
                state_next = S_COL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            step_col_reg <= '0;
            ge1_reg      <= 1'b0;
            ge2_reg      <= 1'b0;
            flush_reg    <= 1'b0;
            last_reg     <= 1'b0;
            rows_cfg_reg <= FRAME_ROWS_RESET;
            cols_cfg_reg <= FRAME_COLS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            step_col_reg <= step_col_next;
            ge1_reg      <= ge1_next;
            ge2_reg      <= ge2_next;
            flush_reg    <= flush_next;
            last_reg     <= last_next;
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
        end
    end

    // A size write takes the idle cycle; hold the input word until it is done.
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign col_addr  = (state_reg == S_IDLE) ? c_eff : step_col_reg;

    always_comb
    begin
        cmd.rd_en    = ((state_reg == S_IDLE) && in_valid && !cfg_valid)
                       || (state_reg == S_FLUSH_RD);
        cmd.col_step = (state_reg == S_COL);
        cmd.flush    = (state_reg != S_IDLE) && flush_reg;
        cmd.row_ge1  = ge1_reg;
        cmd.row_ge2  = ge2_reg;
        cmd.left1    = (step_col_reg != '0);
        cmd.left2    = (step_col_reg > COL_W'(1));
        cmd.load_a   = (state_reg == S_EMIT_A) && status.out_free;
        cmd.load_b   = (state_reg == S_EMIT_B) && status.out_free;
    end

endmodule

// ===== rtl/ssp_datapath.sv =====
// Datapath: column memory, three-column window, sign spread and output register.
module ssp_datapath
    import ssp_pkg::*;
#(
    parameter int MAX_COLS     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dp_cmd_t                        cmd,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_addr,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           frame_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dp_status_t                     status
);

    localparam int WORD_W = SAMPLE_WIDTH + 2;

    // Column word: {latest value, its negative flag, flag of the row above it}.
    logic [WORD_W-1:0] mem [MAX_COLS];

    logic [WORD_W-1:0]              rd_word_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] val0_reg, val1_reg;
    logic                           v0_reg, v1_reg, v2_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           frame_end_reg;
    logic                           out_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0] rd_value;
    logic                           rd_neg;
    logic                           rd_prev_neg;
    logic                           sample_neg;
    logic                           vert;
    logic                           near_a, near_b;
    logic signed [SAMPLE_WIDTH-1:0] res_a, res_b;

    assign rd_value    = rd_word_reg[WORD_W-1:2];
    assign rd_neg      = rd_word_reg[1];
    assign rd_prev_neg = rd_word_reg[0];
    assign sample_neg  = sample_reg[SAMPLE_WIDTH-1];

    always_comb
    begin
        if (cmd.flush)
            vert = rd_neg | (cmd.row_ge1 & rd_prev_neg);
        else
            vert = sample_neg | (cmd.row_ge1 & rd_neg) | (cmd.row_ge2 & rd_prev_neg);
    end

    assign near_a = (cmd.left2 & v2_reg) | v1_reg | v0_reg;
    assign near_b = (cmd.left1 & v1_reg) | v0_reg;

    always_comb
    begin
        res_a = val1_reg;
        if (!val1_reg[SAMPLE_WIDTH-1] && (val1_reg != '0) && near_a)
            res_a = -val1_reg;
        res_b = val0_reg;
        if (!val0_reg[SAMPLE_WIDTH-1] && (val0_reg != '0) && near_b)
            res_b = -val0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_word_reg <= mem[col_addr];
        if (cmd.col_step && !cmd.flush)
            mem[col_addr] <= {sample_reg, sample_neg, rd_neg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en && !cmd.flush)
            sample_reg <= sample_in;
        if (cmd.col_step)
        begin
            val1_reg <= val0_reg;
            val0_reg <= rd_value;
            v2_reg   <= v1_reg;
            v1_reg   <= v0_reg;
            v0_reg   <= vert;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_a || cmd.load_b)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            sample_out_reg <= res_a;
            frame_end_reg  <= 1'b0;
        end
        else if (cmd.load_b)
        begin
            sample_out_reg <= res_b;
            frame_end_reg  <= cmd.flush;
        end
    end

    assign sample_out      = sample_out_reg;
    assign frame_end       = frame_end_reg;
    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// ===== rtl/sign_spread_3x3_stencil.sv =====
// Top level of the 3x3 sign spread stencil over a raster-order sample stream.
//
// Usage:
//   Input channel (in_valid/in_ready, sample_in) takes one signed word per
//   sample of a frame in raster order. Output channel (out_valid/out_ready,
//   sample_out, frame_end) returns the processed frame in raster order, one
//   row behind the input; frame_end marks the last word of the frame.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
//   frame_rows (index 0) and frame_cols (index 1); cfg_ready is high while
//   the block is idle, and a write there holds off the input word.
//   Any size write restarts the frame at row 0, column 0. Write only while idle.
// Steps:
//   Each input word is accepted, then takes a column step, then an emit step
//   per result it releases (0 to 2); the accept reads and the column step
//   rewrites one word of the single-port column memory.
//   The frame's final word then sweeps the stored last row: a read and a
//   column step per column, plus an emit step per result.
// Reset: the output register empties, the position returns to the frame
//   start and the size registers go to 4 x 4; the column memory is not cleared.
// Stall: a result waits in the output register while out_ready is low;
//   the controller, with more to load, holds in emit and takes no new input.
module sign_spread_3x3_stencil
    import ssp_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [COL_W-1:0] col_addr;

    // Sequencing: position tracking, size clamping, emit and flush order.
    ssp_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .col_addr  (col_addr)
    );

    // Storage and arithmetic: column memory, window, output register.
    ssp_datapath #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .col_addr   (col_addr),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status)
    );

endmodule

// ===== rtl/ssp_checker.sv =====
// Port-level checker for the sign spread stencil, bound to the top level.
module ssp_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input logic                           frame_end
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(frame_end))
    else $error("stalled output word changed");

    // Reset empties the output register.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid during reset");

    // An accepted input word occupies the column step in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input accepted during column step");

endmodule

bind sign_spread_3x3_stencil ssp_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ssp_checker (.*);
